FILE: design/sha1_pkg.sv
// Package: SHA-1 constants, types and round helpers.
package sha1_pkg;

  localparam int unsigned LenCountBits = 64;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_e;

  // Control from sequencer to round datapath.
  typedef struct packed {
    logic       init;
    logic       round;
    logic       fold;
    logic [6:0] rnd;
  } rnd_ctl_t;

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] k;
    if (t < 7'd20)      k = 32'h5A827999;
    else if (t < 7'd40) k = 32'h6ED9EBA1;
    else if (t < 7'd60) k = 32'h8F1BBCDC;
    else                k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (t < 7'd20)                         f = (b & c) | (~b & d);
    else if (t >= 7'd40 && t < 7'd60)      f = (b & c) | (b & d) | (c & d);
    else                                   f = b ^ c ^ d;
    return f;
  endfunction

endpackage

FILE: design/sha1_round.sv
// Round datapath: schedule shift line, working variables and chain value.
module sha1_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1_pkg::rnd_ctl_t ctl_i,
  input  logic              wr_i,
  input  logic [7:0]        wr_byte_i,
  input  logic [5:0]        fill_i,
  input  logic              restore_i,
  input  logic [2:0]        sel_i,
  output logic [31:0]       chain_o
);
  import sha1_pkg::*;

  logic [31:0] w_q [16];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h_q [5];
  logic [31:0] w_new, w_cur, tmp;
  logic [3:0]  widx;

  assign widx = fill_i[5:2];
  // Rounds below 16 read slot 0, later rounds expand slots 13, 8, 2 and 0; the line shifts one slot per round.
  assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
                  w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};
  assign w_cur = (ctl_i.rnd < 7'd16) ? w_q[0] : w_new;
  assign tmp = {a_q[26:0], a_q[31:27]} + round_f(ctl_i.rnd, b_q, c_q, d_q) + e_q
             + round_k(ctl_i.rnd) + w_cur;

  // Pack bytes into the schedule or shift it during rounds.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      w_q[widx] <= (fill_i[1:0] == 2'd0) ? {24'd0, wr_byte_i} : {w_q[widx][23:0], wr_byte_i};
    end else if (ctl_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_cur;
    end
  end

  // Advance working variables.
  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
    end else if (ctl_i.round) begin
      a_q <= tmp; b_q <= a_q; c_q <= {b_q[1:0], b_q[31:2]}; d_q <= c_q; e_q <= d_q;
    end
  end

  // Fold into chain value; restore after digest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
    end else if (restore_i) begin
      h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
    end else if (ctl_i.fold) begin
      h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
      h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
    end
  end

  always_comb begin
    case (sel_i)
      3'd0:    chain_o = h_q[0];
      3'd1:    chain_o = h_q[1];
      3'd2:    chain_o = h_q[2];
      3'd3:    chain_o = h_q[3];
      default: chain_o = h_q[4];
    endcase
  end

endmodule

FILE: design/sha1_message_digest_top.sv
// Top level: byte intake, padding sequencer and digest output.
// A byte that fills a block runs init, the 80 rounds and fold while busy; other non-last bytes leave it idle.
// A last item runs pad bytes at one per cycle plus one or two compressions, then
// emits the five digest words on consecutive cycles, strobed by valid_o.
// Throughput is set by the single round unit: 80 rounds per 64-byte block.
// Reset (rst_ni low, asynchronous) restores the initial chain value and clears counts.
module sha1_message_digest_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        has_byte_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  output logic        valid_o,
  output logic [2:0]  word_index_o,
  output logic [31:0] digest_word_o,
  output logic        last_word_o
);
  import sha1_pkg::*;

  state_e state_q, state_d;
  logic [LenCountBits-1:0] cnt_q;
  logic [63:0] len_q;
  logic [5:0]  fill_q;
  logic [6:0]  rnd_q;
  logic [2:0]  widx_q;
  logic        pad_q, last_q;
  logic [3:0]  pidx_q;
  rnd_ctl_t    ctl;
  logic        wr, acc, padwr, restore;
  logic [7:0]  wbyte, padbyte;
  logic [31:0] chain;

  assign acc = start && !busy;
  // Pad stream: 0x80, zeros to 56, then 8 length bytes.
  always_comb begin
    if (!pad_q)              padbyte = PadByte;
    else if (pidx_q == 4'd0) padbyte = 8'd0;
    else                     padbyte = len_q[8*(4'd8-pidx_q) +: 8];
  end
  assign padwr = (state_q == ST_PAD);
  assign wr = (acc && has_byte_i) || padwr;
  assign wbyte = padwr ? padbyte : data_byte_i;
  assign restore = (state_q == ST_EMIT) && (widx_q == 3'd4);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc) begin
        if (has_byte_i && fill_q == 6'd63) state_d = ST_INIT;
        else if (is_last_i)                state_d = ST_PAD;
      end
      ST_INIT:  state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 7'd79) state_d = ST_FOLD;
      ST_FOLD:  state_d = !last_q ? ST_IDLE : (pidx_q == 4'd9) ? ST_EMIT : ST_PAD;
      ST_PAD: begin
        if (fill_q == 6'd63)                         state_d = ST_INIT;
      end
      ST_EMIT:  if (widx_q == 3'd4) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    busy          = (state_q != ST_IDLE);
    ctl.init      = (state_q == ST_INIT);
    ctl.round     = (state_q == ST_ROUND);
    ctl.fold      = (state_q == ST_FOLD);
    ctl.rnd       = rnd_q;
    valid_o       = (state_q == ST_EMIT);
    word_index_o  = widx_q;
    digest_word_o = chain;
    last_word_o   = (widx_q == 3'd4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0; len_q <= '0; fill_q <= '0; rnd_q <= '0;
      widx_q <= '0; pad_q <= 1'b0; last_q <= 1'b0; pidx_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr) fill_q <= fill_q + 6'd1;
      if (acc && has_byte_i) cnt_q <= cnt_q + LenCountBits'(8);
      if (acc && is_last_i) begin
        last_q <= 1'b1;
        len_q  <= 64'(has_byte_i ? cnt_q + LenCountBits'(8) : cnt_q);
      end
      // Track pad progress: 0x80 first, then zero fill, then length bytes.
      if (padwr) begin
        pad_q <= 1'b1;
        if (pad_q && pidx_q == 4'd0 && fill_q == 6'd55) pidx_q <= 4'd1;
        else if (pidx_q != 4'd0) pidx_q <= pidx_q + 4'd1;
        else if (!pad_q && fill_q == 6'd55) pidx_q <= 4'd1;
      end
      if (state_q == ST_ROUND) rnd_q <= rnd_q + 7'd1;
      else rnd_q <= '0;
      if (state_q == ST_EMIT) widx_q <= widx_q + 3'd1;
      if (restore) begin
        cnt_q <= '0; len_q <= '0; fill_q <= '0; widx_q <= '0;
        pad_q <= 1'b0; last_q <= 1'b0; pidx_q <= '0;
      end
    end
  end

  sha1_round u_round (
    .clk_i, .rst_ni, .ctl_i(ctl), .wr_i(wr), .wr_byte_i(wbyte), .fill_i(fill_q),
    .restore_i(restore), .sel_i(widx_q), .chain_o(chain)
  );

`ifndef NO_ASSERTIONS
  a_round_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_INIT |=> state_q == ST_ROUND && rnd_q == 7'd0) else $error("round start");
  a_emit_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_word_o |=> valid_o) else $error("digest beats broken");
  a_fold_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FOLD |-> fill_q == 6'd0) else $error("fold with partial block");
  a_len_at_56: assert property (@(posedge clk_i) disable iff (!rst_ni)
    padwr && pidx_q == 4'd1 |-> fill_q == 6'd56) else $error("length misplaced");
`endif

endmodule

FILE: bench/sha1_digest_checker.sv
// Checker: predicts SHA-1 digest words from accepted beats and compares the output stream.
module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        has_byte_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  input  logic        valid_o,
  input  logic [2:0]  word_index_o,
  input  logic [31:0] digest_word_o,
  input  logic        last_word_o,
  output int          fail_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  word_index;
    logic [31:0] digest_word;
    logic        last_word;
  } digest_beat_t;

  logic [31:0]  chain [5];
  logic [31:0]  sched [16];
  logic [63:0]  bit_len;
  logic [5:0]   fill;
  digest_beat_t expected_words[$];

  assign pending_words = expected_words.size();

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Run the 80-round compression on the held block.
  task automatic compress();
    logic [31:0] a, b, c, d, e, f, k, w, tmp;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        w = rotl(sched[(t + 13) & 15] ^ sched[(t + 8) & 15] ^ sched[(t + 2) & 15]
                 ^ sched[t & 15], 1);
        sched[t & 15] = w;
      end else begin
        w = sched[t];
      end
      if (t < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      tmp = rotl(a, 5) + f + e + k + w;
      e = d; d = c; c = rotl(b, 30); b = a; a = tmp;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  // Pack one byte big-endian; compress on a full block.
  task automatic absorb(input logic [7:0] byte_val);
    sched[fill[5:2]] = (fill[1:0] == 2'd0) ? {24'd0, byte_val}
                                           : {sched[fill[5:2]][23:0], byte_val};
    fill = fill + 6'd1;
    if (fill == 6'd0) compress();
  endtask

  task automatic restart();
    chain[0] = sha1_pkg::H0; chain[1] = sha1_pkg::H1; chain[2] = sha1_pkg::H2;
    chain[3] = sha1_pkg::H3; chain[4] = sha1_pkg::H4;
    bit_len = '0;
    fill = '0;
  endtask

  // Pad, append length and queue the five digest words.
  task automatic finish_message();
    logic [63:0] len;
    len = bit_len;
    absorb(sha1_pkg::PadByte);
    while (fill != 6'd56) absorb(8'h00);
    for (int s = 56; s >= 0; s -= 8) absorb(len[s +: 8]);
    for (int i = 0; i < 5; i++)
      expected_words.push_back('{word_index: 3'(i), digest_word: chain[i],
                                 last_word: (i == 4)});
    restart();
  endtask

  initial begin
    fail_count = 0;
    restart();
  end

  always @(posedge clk_i) begin
    digest_beat_t exp_w;
    if (rst_ni) begin
      // Compare an output beat with the oldest expectation.
      if (valid_o) begin
        if (expected_words.size() == 0) begin
          $error("digest beat with nothing expected: %h", digest_word_o);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (word_index_o !== exp_w.word_index) begin
            $error("word_index exp %0d got %0d", exp_w.word_index, word_index_o);
            fail_count++;
          end
          if (digest_word_o !== exp_w.digest_word) begin
            $error("digest_word exp %h got %h", exp_w.digest_word, digest_word_o);
            fail_count++;
          end
          if (last_word_o !== exp_w.last_word) begin
            $error("last_word exp %0b got %0b", exp_w.last_word, last_word_o);
            fail_count++;
          end
        end
      end
      // Predict on an accepted input beat.
      if (start && !busy) begin
        if (has_byte_i) begin
          bit_len = bit_len + 64'd8;
          absorb(data_byte_i);
        end
        if (is_last_i) finish_message();
      end
    end
  end
endmodule

FILE: bench/sha1_message_digest_top_tb.sv
// Testbench top: drives byte beats into the SHA-1 block and gives the verdict.
module sha1_message_digest_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        has_byte_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        is_last_i = 1'b0;
  logic        valid_o;
  logic [2:0]  word_index_o;
  logic [31:0] digest_word_o;
  logic        last_word_o;
  int          fail_count;
  int          pending_words;

  sha1_message_digest_top dut (.*);
  sha1_digest_checker u_checker (.*);

  initial forever #1 clk_i = ~clk_i;

  // Hang guard.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Send one beat, wait for acceptance, then idle a random gap.
  task automatic send_beat(input logic hb, input logic [7:0] db, input logic last);
    int gap;
    start <= 1'b1; has_byte_i <= hb; data_byte_i <= db; is_last_i <= last;
    do @(posedge clk_i); while (busy);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // A message of n bytes, last byte optionally carrying the end mark.
  task automatic send_message(input int n, input logic bare_end);
    for (int i = 0; i < n; i++)
      send_beat(1'b1, 8'($urandom), (i == n - 1) && !bare_end);
    if (bare_end || n == 0) send_beat(1'b0, 8'($urandom), 1'b1);
  endtask

  initial begin
    int len;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, extremes, ignored bytes, pad boundaries.
    send_beat(1'b0, 8'hFF, 1'b1);
    send_beat(1'b1, 8'h00, 1'b0);
    send_beat(1'b0, 8'hA5, 1'b0);
    send_beat(1'b1, 8'hFF, 1'b1);
    send_beat(1'b0, 8'h5A, 1'b0);
    send_beat(1'b1, 8'h61, 1'b1);
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    // Drain fully before continuing.
    start <= 1'b0;
    while (pending_words != 0) @(posedge clk_i);
    send_message(64, 1'b0);
    // A few short random messages.
    for (int m = 0; m < 4; m++) begin
      len = $urandom_range(0, 3);
      send_message(len, $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) send_beat(1'b0, 8'($urandom), 1'b0);
    end
    start <= 1'b0;
    while (pending_words != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: filelist.f
design/sha1_pkg.sv
design/sha1_round.sv
design/sha1_message_digest_top.sv
bench/sha1_digest_checker.sv
bench/sha1_message_digest_top_tb.sv
